// ===== sv/mrl_pkg.sv =====
// Shared types, constants and helper functions for the maximal repeat
// LCP interval stack. No dependencies; every other file but mrl_fifo imports it.
package mrl_pkg;

  localparam int LenW            = 20;
  localparam int StackDepthDef   = 64;
  localparam int IndexBitsDef    = 20;
  localparam int SymbolBitsDef   = 16;
  localparam int MaxResults      = 64;
  localparam int ResCntW         = 7;
  localparam int FifoDepth       = 2;
  localparam int CfgAddrW        = 3;
  localparam int CfgDataW        = 32;

  localparam logic [LenW-1:0] MinLenReset  = LenW'(1);
  localparam logic [0:0]      RegMinLength = 1'b0;

  typedef struct packed {
    logic            start_new;
    logic [LenW-1:0] lcp_value;
    logic [15:0]     pred_symbol;
  } in_item_t;

  typedef struct packed {
    logic [LenW-1:0] repeat_length;
    logic [LenW-1:0] interval_start;
    logic [LenW-1:0] interval_end;
    logic            last_of_run;
    logic            overflowed;
  } result_t;

  // Two preceding symbols combine to the first if it is nonzero and both
  // agree, otherwise the interval is left-diverse (zero).
  function automatic logic [31:0] common_sym(logic [31:0] a, logic [31:0] b);
    return ((a == 32'd0) || (a != b)) ? 32'd0 : a;
  endfunction

endpackage

// ===== sv/maximal_repeat_lcp_stack.sv =====
// Top level of the maximal repeat finder over a streamed LCP array.
// Instantiates mrl_front, mrl_fifo and mrl_engine; uses mrl_pkg.
//
// Usage: suffix-array entries enter on the input queue port (push/full,
// in_item_i), one transaction per entry in suffix-array order. An entry
// with start_new set opens a new array and clears the interval stack.
// Each reported maximal repeat leaves as one transaction on the result
// queue port (empty/pop, out_item_o); last_of_run marks the final repeat
// caused by an entry, and entries that close no left-diverse interval
// produce nothing. min_length is written over the APB port at byte
// address 0 while the block is idle; reads return it.
// Sequencing: the stack engine takes a command in its idle state; for
// each popped interval it compares in the pop state and then reads the
// new top from the stack memory in the load state (skipped when the stack
// empties), and it closes the pop run in the pop state. A start_new entry
// is taken in the idle state alone.
// A result is held until the next pop or the end of the pop run decides
// its last_of_run bit.
// Reset empties both queues and the stack and clears the overflow flag;
// no clearing pass is needed. When the receiver stalls, the result queue
// fills, the engine waits, and the command queue then raises full.
module maximal_repeat_lcp_stack
  import mrl_pkg::*;
#(
  parameter int STACK_DEPTH = StackDepthDef,
  parameter int INDEX_BITS  = IndexBitsDef,
  parameter int SYMBOL_BITS = SymbolBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  in_item_t            in_item_i,
  output logic                empty,
  input  logic                pop,
  output result_t             out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  // Command word: start flag, lcp, combined symbol, left bound, end index.
  localparam int CmdW = 1 + LenW + SYMBOL_BITS + 2 * INDEX_BITS;
  localparam int ResW = $bits(result_t);

  logic [LenW-1:0] min_len_q;
  logic            cfg_wr;

  logic            cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic [CmdW-1:0] cmd_in, cmd_out;
  logic            res_push, res_full;
  result_t         res_in;
  logic [ResW-1:0] res_out;

  // The configuration port never waits.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[CfgAddrW-1:2] == RegMinLength) ? CfgDataW'(min_len_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MinLenReset;
    end else if (cfg_wr && (paddr[CfgAddrW-1:2] == RegMinLength)) begin
      min_len_q <= pwdata[LenW-1:0];
    end
  end

  // Front end: classifies each entry and tracks the running index.
  mrl_front #(
    .INDEX_BITS  (INDEX_BITS),
    .SYMBOL_BITS (SYMBOL_BITS),
    .CMD_W       (CmdW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .cmd_full_i (cmd_full),
    .item_i     (in_item_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  assign full = cmd_full;

  // Command queue decouples the front end from the stack engine.
  mrl_fifo #(
    .WIDTH (CmdW),
    .DEPTH (FifoDepth)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .full_o  (cmd_full),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (cmd_out)
  );

  mrl_engine #(
    .STACK_DEPTH (STACK_DEPTH),
    .INDEX_BITS  (INDEX_BITS),
    .SYMBOL_BITS (SYMBOL_BITS),
    .CMD_W       (CmdW)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .min_len_i   (min_len_q),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // Result queue lets the engine run on while the receiver stalls.
  mrl_fifo #(
    .WIDTH (ResW),
    .DEPTH (FifoDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (res_full),
    .data_i  (res_in),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_out)
  );

  assign out_item_o = result_t'(res_out);

endmodule

// ===== sv/mrl_fifo.sv =====
// Small first-in first-out queue of fixed-width words.
// Depends on nothing but its parameters.
module mrl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push_ok, pop_ok;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_ok) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (pop_ok) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ===== sv/mrl_front.sv =====
// Front end: accepts input items, tracks the entry index and previous
// symbol, and forms a command word for the stack engine. Uses mrl_pkg.
module mrl_front
  import mrl_pkg::*;
#(
  parameter int INDEX_BITS  = IndexBitsDef,
  parameter int SYMBOL_BITS = SymbolBitsDef,
  parameter int CMD_W       = 1 + LenW + SYMBOL_BITS + 2 * INDEX_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic             cmd_full_i,
  input  in_item_t         item_i,
  output logic             cmd_push_o,
  output logic [CMD_W-1:0] cmd_o
);

  logic [INDEX_BITS-1:0]  idx_q, idx_d;
  logic [SYMBOL_BITS-1:0] prev_q, prev_d;
  logic [SYMBOL_BITS-1:0] sym, bwt;
  logic [INDEX_BITS-1:0]  lb, endi;
  logic                   accept;

  assign accept     = push_i && !cmd_full_i;
  assign cmd_push_o = accept;
  assign sym        = SYMBOL_BITS'(item_i.pred_symbol);

  always_comb begin
    idx_d  = idx_q;
    prev_d = prev_q;
    if (item_i.start_new) begin
      // A new suffix array opens its root interval at index zero.
      lb   = '0;
      endi = '0;
      bwt  = sym;
    end else begin
      lb   = idx_q;
      endi = idx_q + INDEX_BITS'(1);
      bwt  = SYMBOL_BITS'(common_sym(32'(prev_q), 32'(sym)));
    end
    if (accept) begin
      idx_d  = endi;
      prev_d = sym;
    end
  end

  assign cmd_o = {item_i.start_new, item_i.lcp_value, bwt, lb, endi};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      prev_q <= '0;
    end else begin
      idx_q  <= idx_d;
      prev_q <= prev_d;
    end
  end

endmodule

// ===== sv/mrl_engine.sv =====
// Back end: the interval stack sequencer with its stack memory, producing
// results into the output queue. Uses mrl_pkg.
module mrl_engine
  import mrl_pkg::*;
#(
  parameter int STACK_DEPTH = StackDepthDef,
  parameter int INDEX_BITS  = IndexBitsDef,
  parameter int SYMBOL_BITS = SymbolBitsDef,
  parameter int CMD_W       = 1 + LenW + SYMBOL_BITS + 2 * INDEX_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [LenW-1:0]  min_len_i,
  input  logic             cmd_empty_i,
  input  logic [CMD_W-1:0] cmd_i,
  output logic             cmd_pop_o,
  input  logic             res_full_i,
  output logic             res_push_o,
  output result_t          res_o
);

  localparam int CntW  = $clog2(STACK_DEPTH + 1);
  localparam int AddrW = $clog2(STACK_DEPTH);

  typedef struct packed {
    logic [LenW-1:0]        lcp;
    logic [INDEX_BITS-1:0]  lb;
    logic [SYMBOL_BITS-1:0] sym;
  } entry_t;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StPop  = 3'b010,
    StLoad = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   ovf_q, ovf_d;
  logic                   pend_q, pend_d;
  logic [ResCntW-1:0]     nres_q, nres_d;
  entry_t                 top_q, top_d;
  logic [LenW-1:0]        lcp_q, lcp_d;
  logic [INDEX_BITS-1:0]  endi_q, endi_d;
  logic [INDEX_BITS-1:0]  lb_q, lb_d;
  logic [SYMBOL_BITS-1:0] bwt_q, bwt_d;
  logic [SYMBOL_BITS-1:0] tsym_q, tsym_d;
  logic [LenW-1:0]        plen_q, plen_d;
  logic [LenW-1:0]        pstart_q, pstart_d;

  entry_t                 stack_mem_q [STACK_DEPTH];
  entry_t                 rd_q;
  logic                   rd_en, wr_en;
  logic [CntW-1:0]        rd_cnt, wr_cnt;
  entry_t                 wr_data;

  logic                   c_start;
  logic [LenW-1:0]        c_lcp;
  logic [SYMBOL_BITS-1:0] c_bwt;
  logic [INDEX_BITS-1:0]  c_lb, c_endi;
  logic                   do_pop, emit, res_last;

  assign {c_start, c_lcp, c_bwt, c_lb, c_endi} = cmd_i;
  assign rd_cnt = cnt_q - CntW'(2);
  assign wr_cnt = cnt_q - CntW'(1);
  assign do_pop = (cnt_q != '0) && (top_q.lcp > lcp_q);
  assign emit   = (top_q.sym == '0) && (top_q.lcp >= min_len_i)
                  && (nres_q < ResCntW'(MaxResults));

  assign res_o.repeat_length  = plen_q;
  assign res_o.interval_start = pstart_q;
  assign res_o.interval_end   = LenW'(endi_q);
  assign res_o.last_of_run    = res_last;
  assign res_o.overflowed     = ovf_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    pend_d     = pend_q;
    nres_d     = nres_q;
    top_d      = top_q;
    lcp_d      = lcp_q;
    endi_d     = endi_q;
    lb_d       = lb_q;
    bwt_d      = bwt_q;
    tsym_d     = tsym_q;
    plen_d     = plen_q;
    pstart_d   = pstart_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_last   = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    wr_data    = top_q;
    case (state_q)
      StIdle: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          lcp_d     = c_lcp;
          endi_d    = c_endi;
          if (c_start) begin
            cnt_d = CntW'(1);
            top_d = '{lcp: c_lcp, lb: '0, sym: c_bwt};
          end else begin
            lb_d    = c_lb;
            bwt_d   = c_bwt;
            nres_d  = '0;
            state_d = StPop;
          end
        end
      end
      StPop: begin
        if (do_pop) begin
          if (!(emit && pend_q && res_full_i)) begin
            if (emit) begin
              res_push_o = pend_q;
              pend_d     = 1'b1;
              plen_d     = top_q.lcp;
              pstart_d   = LenW'(top_q.lb);
              nres_d     = nres_q + ResCntW'(1);
            end
            lb_d   = top_q.lb;
            bwt_d  = SYMBOL_BITS'(common_sym(32'(top_q.sym), 32'(bwt_q)));
            tsym_d = top_q.sym;
            cnt_d  = cnt_q - CntW'(1);
            if (cnt_q >= CntW'(2)) begin
              rd_en   = 1'b1;
              state_d = StLoad;
            end
          end
        end else if (!(pend_q && res_full_i)) begin
          // End of the pop run: the held result is the last of this item.
          res_push_o = pend_q;
          res_last   = 1'b1;
          pend_d     = 1'b0;
          state_d    = StIdle;
          if ((cnt_q != '0) && (top_q.lcp == lcp_q)) begin
            top_d.sym = SYMBOL_BITS'(common_sym(32'(top_q.sym), 32'(bwt_q)));
          end else if (cnt_q == CntW'(STACK_DEPTH)) begin
            ovf_d = 1'b1;
          end else begin
            wr_en = (cnt_q != '0);
            top_d = '{lcp: lcp_q, lb: lb_q, sym: bwt_q};
            cnt_d = cnt_q + CntW'(1);
          end
        end
      end
      StLoad: begin
        top_d     = rd_q;
        top_d.sym = SYMBOL_BITS'(common_sym(32'(tsym_q), 32'(rd_q.sym)));
        state_d   = StPop;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      pend_q  <= 1'b0;
      nres_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      pend_q  <= pend_d;
      nres_q  <= nres_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q    <= top_d;
    lcp_q    <= lcp_d;
    endi_q   <= endi_d;
    lb_q     <= lb_d;
    bwt_q    <= bwt_d;
    tsym_q   <= tsym_d;
    plen_q   <= plen_d;
    pstart_q <= pstart_d;
  end

  // Entries below the cached top live in this memory.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem_q[wr_cnt[AddrW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= stack_mem_q[rd_cnt[AddrW-1:0]];
    end
  end

endmodule

// ===== sv/mrl_checker.sv =====
// Port-level checks on the result stream of the maximal repeat finder.
// Uses mrl_pkg; bound to maximal_repeat_lcp_stack at the end of the file.
module mrl_checker
  import mrl_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    empty,
  input logic    pop,
  input result_t out_item_o
);

  // A popped interval always had an lcp above the new one, so it is never zero.
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.repeat_length != '0))
    else $error("result with zero repeat length");

  // Within one entry's run the end index is shared and lengths fall strictly.
  a_run_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !out_item_o.last_of_run) |=>
      (empty || ((out_item_o.interval_end == $past(out_item_o.interval_end))
                 && (out_item_o.repeat_length < $past(out_item_o.repeat_length)))))
    else $error("results of one run out of order");

  // The overflow flag never falls once a result has shown it.
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && out_item_o.overflowed) |=> (empty || out_item_o.overflowed))
    else $error("overflow flag cleared");

  // A waiting result stays put while the receiver stalls.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("stalled result changed");

endmodule

bind maximal_repeat_lcp_stack mrl_checker u_mrl_checker (.*);
